// File: hw/rtl/chm_pkg.sv
// Package for the cache hit/miss model: mode codes, hash helpers and the
// saturating increment used by the probe engine.
// No dependencies.
`default_nettype none
package chm_pkg;

   typedef enum logic [1:0] {
      MODE_DIRECT = 2'd0,
      MODE_FULL   = 2'd1,
      MODE_TWO    = 2'd2,
      MODE_FOUR   = 2'd3
   } mode_type;

   localparam logic CSR_MODE       = 1'b0;
   localparam logic CSR_NUM_BLOCKS = 1'b1;

   // One round of the one-at-a-time mix for a sign-extended byte.
   function automatic logic [31:0] oat_round(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] t;
      t = h + {{24{b[7]}}, b};
      t = t + (t << 10);
      t = t ^ (t >> 6);
      return t;
   endfunction

   function automatic logic [31:0] oat_final(input logic [31:0] h);
      logic [31:0] t;
      t = h + (h << 3);
      t = t ^ (t >> 11);
      t = t + (t << 15);
      return t;
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/chm_front.sv
// Front end: accepts an address, hashes it byte by byte and reduces
// the hash modulo the set count by restoring division. Depends on chm_pkg.
`default_nettype none
module chm_front import chm_pkg::*; #(
   parameter int SlotW = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [63:0]      in_addr,
   input  wire logic [SlotW:0]   in_sets,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [63:0]           out_addr,
   output logic [SlotW-1:0]      out_base
);

   typedef enum logic [1:0] {F_IDLE, F_HASH, F_DIV, F_DONE} fstate_type;

   fstate_type        state_ff, state_in;
   logic [3:0]        step_ff, step_in;
   logic [63:0]       addr_ff, addr_in;
   logic [31:0]       hash_ff, hash_in;
   logic [SlotW:0]    sets_ff, sets_in;
   logic [SlotW:0]    rem_ff, rem_in;
   logic [5:0]        bit_ff, bit_in;
   logic [SlotW+1:0]  trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      addr_ff <= addr_in;
      hash_ff <= hash_in;
      sets_ff <= sets_in;
      rem_ff  <= rem_in;
      bit_ff  <= bit_in;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      addr_in  = addr_ff;
      hash_in  = hash_ff;
      sets_in  = sets_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      trial    = {rem_ff, hash_ff[bit_ff[4:0]]};
      in_ready  = (state_ff == F_IDLE);
      out_valid = (state_ff == F_DONE);
      case (state_ff)
         F_IDLE: begin
            if (in_valid) begin
               addr_in  = in_addr;
               sets_in  = in_sets;
               hash_in  = '0;
               step_in  = '0;
               state_in = F_HASH;
            end
         end
         F_HASH: begin
            if (step_ff == 4'd8) begin
               hash_in  = oat_final(hash_ff);
               rem_in   = '0;
               bit_in   = 6'd31;
               state_in = F_DIV;
            end else begin
               hash_in = oat_round(hash_ff, addr_ff[7:0]);
               addr_in = {8'd0, addr_ff[63:8]};
               step_in = step_ff + 4'd1;
            end
         end
         F_DIV: begin
            if (trial >= {1'b0, sets_ff}) begin
               rem_in = SlotW'(trial - {1'b0, sets_ff}) == 0 ? '0
                        : (SlotW+1)'(trial - {1'b0, sets_ff});
            end else begin
               rem_in = (SlotW+1)'(trial);
            end
            if (bit_ff == 6'd0) begin
               state_in = F_DONE;
            end else begin
               bit_in = bit_ff - 6'd1;
            end
         end
         F_DONE: begin
            if (out_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   // The address register is shifted during hashing; keep the original.
   logic [63:0] orig_ff;
   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && in_valid) orig_ff <= in_addr;
   end
   assign out_addr = orig_ff;
   assign out_base = rem_ff[SlotW-1:0];

endmodule
`default_nettype wire

// File: hw/rtl/chm_queue.sv
// Two-entry queue between the front end and the probe engine.
// No dependencies beyond the clock and reset.
`default_nettype none
module chm_queue #(
   parameter int W = 72
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire logic [W-1:0] in_data,
   output logic              out_valid,
   input  wire logic         out_ready,
   output logic [W-1:0]      out_data
);
   logic [W-1:0] mem_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;
   logic         wr, rd;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
      if (wr) mem_ff[wp_ff] <= in_data;
   end
endmodule
`default_nettype wire

// File: hw/rtl/chm_back.sv
// Probe engine: reads and compares the ways of the selected set slot by slot,
// tracks the LRU victim, updates tags, stamps and counters. Uses chm_pkg.
`default_nettype none
module chm_back import chm_pkg::*; #(
   parameter int SlotW = 8,
   parameter int Slots = 256
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire logic [63:0]     in_addr,
   input  wire logic [SlotW-1:0] in_base,
   input  mode_type             mode,
   input  wire logic [SlotW:0]  n_slots,
   input  wire logic [SlotW:0]  sets,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic                 rsp_hit,
   output logic [7:0]           rsp_slot,
   output logic [31:0]          rsp_hits,
   output logic [31:0]          rsp_misses,
   output logic [31:0]          rsp_time
);

   typedef enum logic [2:0] {B_IDLE, B_READ, B_CMP, B_FILL, B_OUT} bstate_type;

   bstate_type       state_ff, state_in;
   logic [63:0]      tag_mem [Slots];
   logic [31:0]      stamp_mem [Slots];
   logic [Slots-1:0] valid_ff;
   logic [63:0]      tag_rd_ff;
   logic [31:0]      stamp_rd_ff;

   logic [63:0]      addr_ff, addr_in;
   logic [SlotW:0]   idx_ff, idx_in;
   logic [SlotW:0]   way_ff, way_in;
   logic [SlotW:0]   ways;
   logic [SlotW-1:0] victim_ff, victim_in;
   logic [31:0]      best_ff, best_in;
   logic             have_ff, have_in;
   logic             hit_ff, hit_in;
   logic [SlotW-1:0] slot_ff, slot_in;
   logic [31:0]      hits_ff, hits_in, miss_ff, miss_in, time_ff, time_in;
   logic             direct_ff, direct_in;
   logic             tag_we, stamp_we;
   logic [SlotW-1:0] wr_idx;
   logic [31:0]      stamp_wd;
   logic             match;
   logic [31:0]      stamp_cur;
   logic [SlotW+1:0] next_idx;

   always_comb begin
      case (mode)
         MODE_FULL: ways = n_slots;
         MODE_TWO:  ways = (SlotW+1)'(2);
         MODE_FOUR: ways = (SlotW+1)'(4);
         default:   ways = (SlotW+1)'(1);
      endcase
   end

   assign match = valid_ff[idx_ff[SlotW-1:0]] && (tag_rd_ff == addr_ff);
   // A slot that has never been filled has never been stamped, so it reads as zero.
   assign stamp_cur = valid_ff[idx_ff[SlotW-1:0]] ? stamp_rd_ff : 32'd0;
   assign next_idx = {1'b0, idx_ff} + {1'b0, sets};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= '0;
         hits_ff  <= '0;
         miss_ff  <= '0;
         time_ff  <= '0;
      end else begin
         state_ff <= state_in;
         hits_ff  <= hits_in;
         miss_ff  <= miss_in;
         time_ff  <= time_in;
         if (tag_we) valid_ff[wr_idx] <= 1'b1;
      end
      if (tag_we) tag_mem[wr_idx] <= addr_ff;
      if (stamp_we) stamp_mem[wr_idx] <= stamp_wd;
      tag_rd_ff   <= tag_mem[idx_ff[SlotW-1:0]];
      stamp_rd_ff <= stamp_mem[idx_ff[SlotW-1:0]];
      addr_ff   <= addr_in;
      idx_ff    <= idx_in;
      way_ff    <= way_in;
      victim_ff <= victim_in;
      best_ff   <= best_in;
      have_ff   <= have_in;
      hit_ff    <= hit_in;
      slot_ff   <= slot_in;
      direct_ff <= direct_in;
   end

   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      idx_in    = idx_ff;
      way_in    = way_ff;
      victim_in = victim_ff;
      best_in   = best_ff;
      have_in   = have_ff;
      hit_in    = hit_ff;
      slot_in   = slot_ff;
      direct_in = direct_ff;
      hits_in   = hits_ff;
      miss_in   = miss_ff;
      time_in   = time_ff;
      tag_we    = 1'b0;
      stamp_we  = 1'b0;
      wr_idx    = idx_ff[SlotW-1:0];
      stamp_wd  = time_ff;
      in_ready  = (state_ff == B_IDLE);
      rsp_valid = (state_ff == B_OUT);
      case (state_ff)
         B_IDLE: begin
            if (in_valid) begin
               addr_in   = in_addr;
               idx_in    = (mode == MODE_FULL) ? '0 : {1'b0, in_base};
               way_in    = '0;
               have_in   = 1'b0;
               hit_in    = 1'b0;
               victim_in = '0;
               best_in   = '0;
               direct_in = (mode == MODE_DIRECT);
               state_in  = B_READ;
            end
         end
         B_READ: state_in = B_CMP;
         B_CMP: begin
            if (direct_ff) begin
               slot_in = idx_ff[SlotW-1:0];
               time_in = sat_inc(time_ff);
               if (match) begin
                  hit_in  = 1'b1;
                  hits_in = sat_inc(hits_ff);
               end else begin
                  tag_we  = 1'b1;
                  if (!valid_ff[idx_ff[SlotW-1:0]]) begin
                     stamp_we = 1'b1;
                     stamp_wd = 32'd0;
                  end
                  miss_in = sat_inc(miss_ff);
               end
               state_in = B_OUT;
            end else begin
               time_in = sat_inc(time_ff);
               if (match) begin
                  hit_in   = 1'b1;
                  slot_in  = idx_ff[SlotW-1:0];
                  stamp_we = 1'b1;
                  stamp_wd = sat_inc(time_ff);
                  hits_in  = sat_inc(hits_ff);
                  state_in = B_OUT;
               end else begin
                  if (!have_ff || stamp_cur < best_ff) begin
                     best_in   = stamp_cur;
                     victim_in = idx_ff[SlotW-1:0];
                     have_in   = 1'b1;
                  end
                  way_in = way_ff + (SlotW+1)'(1);
                  if (way_ff + (SlotW+1)'(1) >= ways || next_idx >= (SlotW+2)'(Slots)) begin
                     state_in = B_FILL;
                  end else begin
                     idx_in   = next_idx[SlotW:0];
                     state_in = B_READ;
                  end
               end
            end
         end
         B_FILL: begin
            wr_idx   = victim_ff;
            tag_we   = 1'b1;
            stamp_we = 1'b1;
            slot_in  = victim_ff;
            miss_in  = sat_inc(miss_ff);
            state_in = B_OUT;
         end
         B_OUT: begin
            if (rsp_ready) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign rsp_hit    = hit_ff;
   assign rsp_slot   = 8'(slot_ff);
   assign rsp_hits   = hits_ff;
   assign rsp_misses = miss_ff;
   assign rsp_time   = time_ff;

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_OUT && !rsp_ready) |=> (state_ff == B_OUT && $stable(hits_ff)))
      else $error("result changed while waiting");
   a_time_mono: assert property (@(posedge clock) disable iff (reset)
      time_ff >= $past(time_ff) || $past(reset))
      else $error("probe time went backwards");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_IDLE) |=> ($stable(hits_ff) && $stable(miss_ff)))
      else $error("counters moved while idle");
endmodule
`default_nettype wire

// File: hw/rtl/cache_hit_miss_model.sv
// Cache hit/miss model, top level. A request passes the front end, the queue and the
// probe engine, which reads and compares each of the k ways probed, plus a fill step on
// an associative miss. The front end hashes and then divides; it takes a new request only
// once its result is taken. The engine probes up to k ways per request, all slots in
// fully associative mode. The queue lets the front end work ahead.
// Synchronous reset clears all valid bits; a slot never filled reads as stamp zero.
`default_nettype none
module cache_hit_miss_model import chm_pkg::*; #(
   parameter int MaxSlots = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [63:0] req_address,
   output logic             empty,
   input  wire logic        pop,
   output logic             rsp_hit,
   output logic [7:0]       rsp_slot,
   output logic [31:0]      rsp_hit_count,
   output logic [31:0]      rsp_miss_count,
   output logic [31:0]      rsp_access_time,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [8:0]  csr_wdata
);
   localparam int SlotW = $clog2(MaxSlots);
   localparam int QW = 64 + SlotW;

   mode_type       mode_ff;
   logic [8:0]     nblk_ff;
   logic [SlotW:0] n_slots, sets;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DIRECT;
         nblk_ff <= 9'd256;
      end else if (csr_we) begin
         if (csr_index == CSR_MODE) mode_ff <= mode_type'(csr_wdata[1:0]);
         else nblk_ff <= csr_wdata;
      end
   end

   always_comb begin
      if ((SlotW+1)'(nblk_ff) < (SlotW+1)'(4) && nblk_ff < 9'd4) n_slots = (SlotW+1)'(4);
      else if ({{(SlotW+1){1'b0}}, nblk_ff} > (SlotW+10)'(MaxSlots))
         n_slots = (SlotW+1)'(MaxSlots);
      else n_slots = (SlotW+1)'(nblk_ff);
      case (mode_ff)
         MODE_TWO:  sets = n_slots >> 1;
         MODE_FOUR: sets = n_slots >> 2;
         MODE_FULL: sets = (SlotW+1)'(1);
         default:   sets = n_slots;
      endcase
   end

   logic              f_valid, f_ready, q_valid, q_ready;
   logic [63:0]       f_addr;
   logic [SlotW-1:0]  f_base;
   logic [QW-1:0]     q_data;
   logic              in_ready, rsp_valid;

   assign full  = !in_ready;
   assign empty = !rsp_valid;

   chm_front #(.SlotW(SlotW)) u_front (
      .clock, .reset,
      .in_valid(push), .in_ready(in_ready), .in_addr(req_address), .in_sets(sets),
      .out_valid(f_valid), .out_ready(f_ready), .out_addr(f_addr), .out_base(f_base)
   );

   chm_queue #(.W(QW)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data({f_addr, f_base}),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   chm_back #(.SlotW(SlotW), .Slots(MaxSlots)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready),
      .in_addr(q_data[QW-1:SlotW]), .in_base(q_data[SlotW-1:0]),
      .mode(mode_ff), .n_slots(n_slots), .sets(sets),
      .rsp_valid(rsp_valid), .rsp_ready(pop),
      .rsp_hit, .rsp_slot, .rsp_hits(rsp_hit_count), .rsp_misses(rsp_miss_count),
      .rsp_time(rsp_access_time)
   );
endmodule
`default_nettype wire
